// File: rtl/core/sorted_key_table_insert_lookup_defines.svh
// assertion helpers for the sorted key table
`ifndef SORTED_KEY_TABLE_INSERT_LOOKUP_DEFINES_SVH
`define SORTED_KEY_TABLE_INSERT_LOOKUP_DEFINES_SVH

`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define SKTI_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// antecedent implies consequent in the next cycle
`define SKTI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SKTI_ASSERT_IMPL(label, ante, cons)
`define SKTI_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: rtl/core/skti_pkg.sv
package skti_pkg;

  localparam int CAPACITY = 64;
  localparam int KEY_W    = 64;
  localparam int PAY_W    = 32;
  localparam int IDX_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 7;
  localparam int STAT_W   = 3;

  typedef logic [KEY_W-1:0] key_t;
  typedef logic [PAY_W-1:0] pay_t;
  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_INSERT = 1'b1
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_HIT       = 3'd3,
    ST_MISS      = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    FSM_IDLE = 3'b001,
    FSM_CMP  = 3'b010,
    FSM_UPD  = 3'b100
  } fsm_t;

  // broadcast to every cell of the row
  typedef struct packed {
    logic cmp_en;
    logic ins_en;
    key_t key;
    pay_t payload;
  } cell_ctl_t;

endpackage

// File: rtl/core/skti_if.sv
interface skti_in_if;
  import skti_pkg::*;
  logic valid;
  logic ready;
  logic op;
  logic [KEY_W-1:0] key;
  logic [PAY_W-1:0] payload;
  modport source (output valid, output op, output key, output payload, input ready);
  modport sink   (input valid, input op, input key, input payload, output ready);
endinterface

interface skti_out_if;
  import skti_pkg::*;
  logic valid;
  logic ready;
  logic [STAT_W-1:0] status;
  logic found;
  logic [POS_W-1:0] position;
  logic [PAY_W-1:0] payload_out;
  logic [POS_W-1:0] entry_total;
  modport source (output valid, output status, output found, output position,
                  output payload_out, output entry_total, input ready);
  modport sink   (input valid, input status, input found, input position,
                  input payload_out, input entry_total, output ready);
endinterface

// File: rtl/core/skti_cell.sv
module skti_cell (
  input  logic                clk,
  input  skti_pkg::cell_ctl_t ctl,
  input  logic                occ,
  input  logic                lt_prev_c,
  input  logic                lt_prev_r,
  input  skti_pkg::key_t      prev_key,
  input  skti_pkg::pay_t      prev_pay,
  output logic                lt_c,
  output logic                lt_r,
  output logic                first_r,
  output logic                hit_r,
  output skti_pkg::pay_t      pay_hit_r,
  output skti_pkg::key_t      key_r,
  output skti_pkg::pay_t      pay_r
);
  import skti_pkg::*;

  logic eq_c;
  logic first_c;

  assign lt_c    = occ & (key_r < ctl.key);
  assign eq_c    = occ & (key_r == ctl.key);
  // first cell that is empty or whose key is not below the search key
  assign first_c = ~lt_c & lt_prev_c;

  always_ff @(posedge clk) begin
    if (ctl.cmp_en) begin
      lt_r      <= lt_c;
      first_r   <= first_c;
      hit_r     <= first_c & eq_c;
      pay_hit_r <= (first_c & eq_c) ? pay_r : '0;
    end
  end

  // cells at and above the insertion point move up one place
  always_ff @(posedge clk) begin
    if (ctl.ins_en && !lt_r) begin
      key_r <= lt_prev_r ? ctl.key : prev_key;
      pay_r <= lt_prev_r ? ctl.payload : prev_pay;
    end
  end

endmodule

// File: rtl/core/skti_enc.sv
module skti_enc (
  input  logic [skti_pkg::CAPACITY-1:0] first_vec,
  input  skti_pkg::pay_t                pay_hit [skti_pkg::CAPACITY],
  output skti_pkg::idx_t                pos,
  output skti_pkg::pay_t                pay
);
  import skti_pkg::*;

  idx_t pos_or;

  always_comb begin
    pos_or = '0;
    pay    = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      pos_or = pos_or | (first_vec[i] ? IDX_W'(i) : '0);
      pay    = pay | pay_hit[i];
    end
  end

  // no boundary in the row: every slot is taken and below the key
  assign pos = (|first_vec) ? pos_or : IDX_W'(CAPACITY);

endmodule

// File: rtl/core/sorted_key_table_insert_lookup.sv
// a request passes the compare state and then the update state through the row of
//   cells before its result is registered; one request in flight at a time, and the
//   update waits for room in the output register before a new request is accepted
// reset: rst_n synchronous active low clears the entry count and the handshake
//   state; stored keys and payloads are left as they are, no clearing pass
`include "sorted_key_table_insert_lookup_defines.svh"

module sorted_key_table_insert_lookup (
  input  logic       clk,
  input  logic       rst_n,
  skti_in_if.sink    in_req,
  skti_out_if.source out_rsp
);
  import skti_pkg::*;

  fsm_t state_r, state_nxt;

  // request held while it walks the cell row
  logic op_r;
  key_t key_r;
  pay_t pay_r;

  idx_t count_r, count_nxt;

  // output register, parts the two sides
  logic              out_valid_r;
  logic [STAT_W-1:0] status_r;
  logic              found_r;
  logic [POS_W-1:0]  position_r;
  pay_t              payload_out_r;
  logic [POS_W-1:0]  entry_total_r;

  logic in_fire;
  logic out_free;
  logic upd_go;
  logic full;
  logic hit;
  logic ins_ok;
  idx_t enc_pos;
  pay_t enc_pay;
  status_t status_c;

  cell_ctl_t ctl;

  logic [CAPACITY-1:0] occ;
  logic [CAPACITY-1:0] lt_c_w;
  logic [CAPACITY-1:0] lt_r_w;
  logic [CAPACITY-1:0] first_w;
  logic [CAPACITY-1:0] hit_w;
  pay_t pay_hit_w [CAPACITY];
  key_t cell_key_w [CAPACITY];
  pay_t cell_pay_w [CAPACITY];

  assign in_req.ready = (state_r == FSM_IDLE);
  assign in_fire      = in_req.valid & in_req.ready;
  assign out_free     = ~out_valid_r | out_rsp.ready;
  // the update pass waits for room in the output register
  assign upd_go       = (state_r == FSM_UPD) & out_free;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FSM_IDLE: if (in_fire) state_nxt = FSM_CMP;
      FSM_CMP:  state_nxt = FSM_UPD;
      FSM_UPD:  if (out_free) state_nxt = FSM_IDLE;
      default:  state_nxt = FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FSM_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r  <= in_req.op;
      key_r <= in_req.key;
      pay_r <= in_req.payload;
    end
  end

  // slot occupancy follows from the entry count
  for (genvar i = 0; i < CAPACITY; i++) begin : g_occ
    assign occ[i] = (IDX_W'(i) < count_r);
  end

  assign ctl.cmp_en  = (state_r == FSM_CMP);
  assign ctl.ins_en  = ins_ok;
  assign ctl.key     = key_r;
  assign ctl.payload = pay_r;

  // row of compare-and-shift cells, each talks to its lower neighbor
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_head
      skti_cell u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .occ       (occ[i]),
        .lt_prev_c (1'b1),
        .lt_prev_r (1'b1),
        .prev_key  (key_r),
        .prev_pay  (pay_r),
        .lt_c      (lt_c_w[i]),
        .lt_r      (lt_r_w[i]),
        .first_r   (first_w[i]),
        .hit_r     (hit_w[i]),
        .pay_hit_r (pay_hit_w[i]),
        .key_r     (cell_key_w[i]),
        .pay_r     (cell_pay_w[i])
      );
    end else begin : g_body
      skti_cell u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .occ       (occ[i]),
        .lt_prev_c (lt_c_w[i-1]),
        .lt_prev_r (lt_r_w[i-1]),
        .prev_key  (cell_key_w[i-1]),
        .prev_pay  (cell_pay_w[i-1]),
        .lt_c      (lt_c_w[i]),
        .lt_r      (lt_r_w[i]),
        .first_r   (first_w[i]),
        .hit_r     (hit_w[i]),
        .pay_hit_r (pay_hit_w[i]),
        .key_r     (cell_key_w[i]),
        .pay_r     (cell_pay_w[i])
      );
    end
  end

  skti_enc u_enc (
    .first_vec (first_w),
    .pay_hit   (pay_hit_w),
    .pos       (enc_pos),
    .pay       (enc_pay)
  );

  // full table on insert skips the search result entirely
  assign full   = (op_r == OP_INSERT) & (count_r >= IDX_W'(CAPACITY));
  assign hit    = |hit_w;
  assign ins_ok = upd_go & (op_r == OP_INSERT) & ~full & ~hit;

  always_comb begin
    priority if (op_r == OP_LOOKUP) begin
      status_c = hit ? ST_HIT : ST_MISS;
    end else if (full) begin
      status_c = ST_FULL;
    end else if (hit) begin
      status_c = ST_DUPLICATE;
    end else begin
      status_c = ST_INSERTED;
    end
  end

  assign count_nxt = count_r + IDX_W'(ins_ok);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (upd_go) begin
      out_valid_r <= 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_go) begin
      status_r      <= status_c;
      found_r       <= ~full & hit;
      position_r    <= full ? '0 : POS_W'(enc_pos);
      payload_out_r <= full ? '0 : enc_pay;
      entry_total_r <= POS_W'(count_nxt);
    end
  end

  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.status      = status_r;
  assign out_rsp.found       = found_r;
  assign out_rsp.position    = position_r;
  assign out_rsp.payload_out = payload_out_r;
  assign out_rsp.entry_total = entry_total_r;

  // entry count stays within the table
  `SKTI_ASSERT_IMPL(a_count_bound, 1'b1, count_r <= IDX_W'(CAPACITY))
  // an accepted request always goes to the compare pass
  `SKTI_ASSERT_NEXT(a_accept_cmp, in_fire, state_r == FSM_CMP)
  // at most one insertion boundary in the row
  `SKTI_ASSERT_IMPL(a_first_onehot, state_r == FSM_UPD, $onehot0(first_w))
  // a successful insert grows the table by exactly one
  `SKTI_ASSERT_NEXT(a_insert_count, ins_ok, count_r == $past(count_r) + 1'b1)

endmodule
